/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* design/utt_pkg.sv */
// ---------------------------------------------------------------------------
// utt_pkg
// shared types and constants of the utf-8 to utf-16 transcoder
// ---------------------------------------------------------------------------
package utt_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [5:0]  HI_SURR   = 6'b110110;
    localparam logic [5:0]  LO_SURR   = 6'b110111;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // what the back end has to send for one job
    typedef enum logic [1:0] {
        K_UNIT  = 2'd0,
        K_PAIR  = 2'd1,
        K_TRUNC = 2'd2,
        K_RANGE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* design/utt_front.sv */
// ---------------------------------------------------------------------------
// utt_front
// accepts utf-8 words, gathers sequences and queues one job per character
// ---------------------------------------------------------------------------
module utt_front
    import utt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_action,
    input  logic [7:0] i_in_byte,
    output logic       o_stall,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]  r_pending, n_pending;
    logic [14:0] r_partial, n_partial;
    logic        accept;
    logic [20:0] cp_cont;

    function automatic t_job classify(input logic [20:0] cp);
        logic [20:0] v;
        t_job        j;
        v       = cp - SUPP_BASE;
        j.unit1 = {LO_SURR, v[9:0]};
        if (cp < SUPP_BASE) begin
            j.kind  = K_UNIT;
            j.unit0 = cp[15:0];
        end else if (cp > MAX_CP) begin
            j.kind  = K_RANGE;
            j.unit0 = cp[15:0];
        end else begin
            j.kind  = K_PAIR;
            j.unit0 = {HI_SURR, v[19:10]};
        end
        return j;
    endfunction

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign cp_cont = {r_partial, i_in_byte[5:0]};

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        o_push      = 1'b0;
        o_job       = classify({13'd0, i_in_byte});
        if (accept) begin
            if (i_action) begin
                if (r_pending != 2'd0) begin
                    o_push      = 1'b1;
                    o_job.kind  = K_TRUNC;
                    n_pending   = 2'd0;
                    n_partial   = '0;
                end
            end else if (r_pending != 2'd0) begin
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    o_push    = 1'b1;
                    o_job     = classify(cp_cont);
                    n_partial = '0;
                end else begin
                    n_partial = cp_cont[14:0];
                end
            end else if (i_in_byte inside {[8'hF0:8'hF7]}) begin
                n_pending = 2'd3;
                n_partial = {12'd0, i_in_byte[2:0]};
            end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
                n_pending = 2'd2;
                n_partial = {11'd0, i_in_byte[3:0]};
            end else if (i_in_byte inside {[8'hC0:8'hDF]}) begin
                n_pending = 2'd1;
                n_partial = {10'd0, i_in_byte[4:0]};
            end else begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
        end else begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

endmodule

/* design/utt_queue.sv */
// ---------------------------------------------------------------------------
// utt_queue
// short job queue between the front and back ends
// ---------------------------------------------------------------------------
module utt_queue
    import utt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_job         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* design/utt_back.sv */
// ---------------------------------------------------------------------------
// utt_back
// sends each job as utf-16 words in the configured byte order or an error word
// ---------------------------------------------------------------------------
module utt_back
    import utt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  t_qstat     i_qstat,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic [1:0] o_error
);

    logic        r_le;
    logic        r_valid, n_valid;
    t_job        r_job, n_job;
    logic [1:0]  r_idx, n_idx;
    logic [15:0] unit;
    logic        hi_sel;
    logic        take;

    assign unit   = r_idx[1] ? r_job.unit1 : r_job.unit0;
    assign hi_sel = ~(r_idx[0] ^ r_le);

    always_comb begin
        o_out_byte = hi_sel ? unit[15:8] : unit[7:0];
        o_error    = ERR_NONE;
        case (r_job.kind)
            K_UNIT:  o_last = (r_idx == 2'd1);
            K_PAIR:  o_last = (r_idx == 2'd3);
            K_TRUNC: begin
                o_last     = 1'b1;
                o_error    = ERR_TRUNC;
                o_out_byte = 8'd0;
            end
            K_RANGE: begin
                o_last     = 1'b1;
                o_error    = ERR_RANGE;
                o_out_byte = 8'd0;
            end
            default: o_last = 1'b1;
        endcase
    end

    assign o_valid = r_valid;
    // free for the next job when idle or when the final word leaves now
    assign take    = !r_valid || (!i_stall && o_last);
    assign o_pop   = take && !i_qstat.empty;

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        n_idx   = r_idx;
        if (take) begin
            n_valid = !i_qstat.empty;
            n_job   = i_job;
            n_idx   = 2'd0;
        end else if (!i_stall) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (!i_rst_n) begin
            r_le    <= 1'b1;
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_le <= i_cfg_wdata;
            end
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

endmodule

/* design/utf8_to_utf16_transcoder.sv */
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// utf-8 word stream in, utf-16 word stream out, selectable byte order
// ---------------------------------------------------------------------------
// One utf-8 byte or end-of-stream mark is taken per cycle, when the queue
// is not full, into a front end that gathers multi-byte sequences and
// queues one job per finished character; a back end drains the queue and
// sends one output byte per cycle when the output is not stalled. The
// byte-wide output port sets the sustained rate: a one-, two- or three-byte
// character is sent as two output bytes, a four-byte character as four
// (one error word when its code point is out of range) and a truncation
// error as one error word. The queue holds QUEUE_DEPTH jobs, so input
// keeps flowing for a while under output stall. A completing input word
// is written to the queue, then to the back end job register. The byte
// order register resets to little endian; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_to_utf16_transcoder
    import utt_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic [1:0] o_error
);

    t_qstat qstat;
    logic   push;
    logic   pop;
    t_job   push_job;
    t_job   head_job;

    utt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_action  (i_action),
        .i_in_byte (i_in_byte),
        .o_stall   (o_stall),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_job     (push_job)
    );

    utt_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    utt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_qstat     (qstat),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, push && qstat.full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && qstat.empty, "pop from empty queue")
    `ASSERT_PROP(a_err_word, i_clk, i_rst_n,
        o_valid && (o_error != ERR_NONE) |-> o_last && (o_out_byte == 8'd0),
        "error word not final or not zero")
    `ASSERT_PROP(a_char_cont, i_clk, i_rst_n,
        o_valid && !i_stall && !o_last |=> o_valid,
        "gap inside a character")

endmodule
